### sv/mbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

  // Pattern storage is fixed by the register map: two 64-bit words.
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  // Wide enough for a cell index up to 127 and for the length.
  localparam int IDX_W     = 7;
  localparam int LEN_W     = 5;
  localparam int ADDR_W    = 64;
  localparam int PADDR_W   = 6;

  typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

  typedef enum logic [2:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LEN    = 3'd3,
    REG_BASE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/mbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mbps_cell #(
  parameter int J = 0
) (
  input  wire                            clk,
  input  wire mbps_pkg::cell_ctl_t       ctl,
  input  wire  [7:0]                     byte_in,
  input  wire mbps_pkg::pat_bytes_t      pattern,
  input  wire  [mbps_pkg::PAT_BYTES-1:0] care,
  input  wire  [mbps_pkg::LEN_W-1:0]     len,
  output logic [7:0]                     byte_out,
  output logic                           eq
);
  import mbps_pkg::*;

  localparam logic [IDX_W-1:0] JIDX = IDX_W'(J);
  localparam bit               HEAD = (J == 0);

  logic [7:0]       byte_r;
  logic [7:0]       byte_nxt;
  logic [IDX_W-1:0] lenx;
  logic [IDX_W-1:0] k;
  logic             care_sel;

  // Entry J lines up with pattern byte len-1-J; the head cell takes the new byte
  // even on the first transfer of a region, the rest start from zero.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      if (HEAD || !ctl.clr) begin
        byte_nxt = byte_in;
      end else begin
        byte_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  always_comb begin
    lenx     = IDX_W'(len);
    k        = lenx - IDX_W'(1) - JIDX;
    care_sel = (lenx > JIDX) && (k < IDX_W'(PAT_BYTES)) && care[k[PAT_IDX_W-1:0]];
    eq       = !care_sel || (byte_r == pattern[k[PAT_IDX_W-1:0]]);
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

### sv/masked_byte_pattern_search.sv
// Wildcard byte pattern search over a memory region.
// Input channel: one byte of the region per transfer (in_data_byte), in address
// order, with in_last_byte on the final byte. Each region gives exactly one
// result on the output channel: out_found and out_match_address (base address
// plus the start offset of the first match, or zero when nothing matched).
// The pattern, care mask, length and base address are written over APB into
// 64-bit registers at 8-byte spacing; the user must write them only while the
// block is idle, which the block itself does not enforce. Throughput: one byte
// per cycle while in_ready is high. The window is a row of byte cells that
// shift on every input transfer; the compare of the whole window and the
// address add take one further register stage, so the result is loaded into
// the output register when the last byte advances out of the first stage.
// A stalled output holds its result; one more region's bytes can still be taken
// until its own last byte reaches the compare stage, then in_ready drops.
// Reset clears the registers, the offset counter, the match state and the
// output valid; the first byte after reset starts a new region.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   in_data_byte,
  input  wire                          in_last_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output logic [mbps_pkg::ADDR_W-1:0]  out_match_address,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [mbps_pkg::PADDR_W-1:0] paddr,
  input  wire  [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import mbps_pkg::*;

  // Registers
  logic [63:0]          pat_lo_r, pat_hi_r, base_r;
  logic [PAT_BYTES-1:0] care_r;
  logic [LEN_W-1:0]     len_r;
  logic                 wr_en;
  reg_idx_t             widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= '0;
      base_r   <= '0;
    end else if (wr_en) begin
      case (widx)
        REG_PAT_LO: pat_lo_r <= pwdata;
        REG_PAT_HI: pat_hi_r <= pwdata;
        REG_CARE:   care_r   <= pwdata[PAT_BYTES-1:0];
        REG_LEN:    len_r    <= pwdata[LEN_W-1:0];
        REG_BASE:   base_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_PAT_LO: prdata = pat_lo_r;
      REG_PAT_HI: prdata = pat_hi_r;
      REG_CARE:   prdata = 64'(care_r);
      REG_LEN:    prdata = 64'(len_r);
      REG_BASE:   prdata = base_r;
      default:    prdata = '0;
    endcase
  end

  // Input stage
  logic                   in_xfer;
  logic                   adv;
  logic                   new_region_r;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] lm1;
  logic                   len_ok, off_ok;
  logic                   s1_v_r, s1_last_r, s1_ok_r;
  logic [OFFSET_BITS-1:0] s1_start_r;

  assign in_ready = !s1_v_r || adv;
  assign in_xfer  = in_valid && in_ready;

  assign lm1    = OFFSET_BITS'(len_r - LEN_W'(1));
  assign len_ok = (len_r != '0) && (IDX_W'(len_r) <= IDX_W'(MAX_PATTERN));
  assign off_ok = (pos_r != '1) && (pos_r >= lm1);

  always_comb begin
    pos_nxt = pos_r;
    if (in_xfer) begin
      if (in_last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != '1) begin
        pos_nxt = pos_r + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      new_region_r <= 1'b1;
      s1_v_r       <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (in_xfer) begin
        new_region_r <= in_last_byte;
        s1_v_r       <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_last_r  <= in_last_byte;
      s1_ok_r    <= len_ok && off_ok;
      s1_start_r <= pos_r - lm1;
    end
  end

  // Window: row of byte cells
  pat_bytes_t             pattern;
  cell_ctl_t              ctl;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0] eq;

  assign pattern   = {pat_hi_r, pat_lo_r};
  assign ctl.shift = in_xfer;
  assign ctl.clr   = new_region_r;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] cin;
    if (j == 0) begin : g_head
      assign cin = in_data_byte;
    end else begin : g_link
      assign cin = win[j-1];
    end
    mbps_cell #(.J(j)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .byte_in  (cin),
      .pattern  (pattern),
      .care     (care_r),
      .len      (len_r),
      .byte_out (win[j]),
      .eq       (eq[j])
    );
  end

  // Compare stage and region state
  logic              hit;
  logic              matched_r;
  logic [ADDR_W-1:0] maddr_r;
  logic [ADDR_W-1:0] hit_addr;
  logic              out_valid_r;
  logic              found_r;
  logic [ADDR_W-1:0] oaddr_r;

  assign adv      = s1_v_r && (!s1_last_r || !out_valid_r || out_ready);
  assign hit      = s1_ok_r && (&eq);
  assign hit_addr = base_r + ADDR_W'(s1_start_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        if (s1_last_r) begin
          matched_r <= 1'b0;
        end else if (hit) begin
          matched_r <= 1'b1;
        end
      end
      if (adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !s1_last_r && !matched_r && hit) begin
      maddr_r <= hit_addr;
    end
    if (adv && s1_last_r) begin
      found_r <= matched_r || hit;
      if (matched_r) begin
        oaddr_r <= maddr_r;
      end else if (hit) begin
        oaddr_r <= hit_addr;
      end else begin
        oaddr_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_match_address = oaddr_r;

endmodule

`default_nettype wire
